// File: design/rse_pkg.sv
package rse_pkg;

  localparam int VALUE_W      = 32;
  localparam int RAND_W       = 16;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int DIV_CNT_W    = $clog2(RAND_W + 1);
  localparam int CAPACITY_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXISTS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd3;

  typedef struct packed {
    logic                load;
    logic                scan;
    logic                div_step;
    logic                rd_last;
    logic                rd_sample;
    logic                wr_append;
    logic                wr_move;
    logic                out_load;
    logic                res_ok;
    logic [STATUS_W-1:0] res_status;
    logic                res_sample;
  } rse_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             hit;
    logic             miss;
    logic             count_zero;
    logic             full;
    logic             div_done;
  } rse_sts_t;

endpackage

// File: design/randomized_set_engine.sv
// Insert/remove search the stored entries one entry per cycle until a hit at slot p or the
//   end of the set; a remove hit then reads the last entry and moves it into slot p.
// Sample: 16-step restoring divider for random mod count, then one read;
//   sample of an empty set or unused command goes straight to the result.
// One beat in flight: the next beat is taken the cycle after the result is registered,
//   also while it waits. Reset (rst_n low, synchronous) empties the set; store not cleared.
module randomized_set_engine
  import rse_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [RAND_W-1:0]         in_random,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_ok,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_sample_value,
  output logic [CNT_W-1:0]          out_count
);

  rse_ctl_t ctl;
  rse_sts_t sts;

  rse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  rse_datapath #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_random        (in_random),
    .out_ok           (out_ok),
    .out_status       (out_status),
    .out_sample_value (out_sample_value),
    .out_count        (out_count)
  );

endmodule

// File: design/rse_datapath.sv
module rse_datapath
  import rse_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rse_ctl_t                  ctl,
  output rse_sts_t                  sts,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [RAND_W-1:0]         in_random,
  output logic                      out_ok,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_sample_value,
  output logic [CNT_W-1:0]          out_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [VALUE_W-1:0] mem [CAPACITY];

  logic [CMD_W-1:0]    cmd_r;
  logic [VALUE_W-1:0]  value_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [VALUE_W-1:0]  rdata_r;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [RAND_W-1:0]   quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic                rd_en;
  logic [IDX_W-1:0]    raddr;
  logic                wr_en;
  logic [IDX_W-1:0]    waddr;
  logic [VALUE_W-1:0]  wdata;
  logic [CNT_W-1:0]    count_m1;
  logic [CNT_W:0]      div_sh;
  logic [CNT_W:0]      div_diff;

  logic                out_ok_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_sample_r;
  logic [CNT_W-1:0]    out_count_r;

  assign count_m1 = count_r - CNT_W'(1);
  assign div_sh   = {rem_r, quo_r[RAND_W-1]};
  assign div_diff = div_sh - {1'b0, count_r};

  assign sts.cmd        = cmd_r;
  assign sts.hit        = cmp_vld_r && (rdata_r == value_r);
  assign sts.miss       = !cmp_vld_r && (scan_r == count_r);
  assign sts.count_zero = (count_r == '0);
  assign sts.full       = (count_r == CAP_CNT);
  assign sts.div_done   = (div_cnt_r == DIV_CNT_W'(RAND_W));

  always_comb begin
    scan_nxt    = scan_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    div_cnt_nxt = div_cnt_r;
    rd_en       = 1'b0;
    raddr       = '0;
    wr_en       = 1'b0;
    waddr       = '0;
    wdata       = rdata_r;

    if (ctl.load) begin
      scan_nxt    = '0;
      rem_nxt     = '0;
      quo_nxt     = in_random;
      div_cnt_nxt = '0;
    end

    if (ctl.scan) begin
      if (scan_r < count_r) begin
        rd_en       = 1'b1;
        raddr       = scan_r[IDX_W-1:0];
        scan_nxt    = scan_r + CNT_W'(1);
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = scan_r[IDX_W-1:0];
      end
      if (sts.hit) begin
        pos_nxt = cmp_idx_r;
      end
    end

    if (ctl.div_step) begin
      quo_nxt     = {quo_r[RAND_W-2:0], 1'b0};
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
      if (!div_diff[CNT_W]) begin
        rem_nxt = div_diff[CNT_W-1:0];
      end else begin
        rem_nxt = div_sh[CNT_W-1:0];
      end
    end

    if (ctl.rd_last) begin
      rd_en = 1'b1;
      raddr = count_m1[IDX_W-1:0];
    end

    if (ctl.rd_sample) begin
      rd_en = 1'b1;
      raddr = rem_r[IDX_W-1:0];
    end

    if (ctl.wr_append) begin
      wr_en     = 1'b1;
      waddr     = count_r[IDX_W-1:0];
      wdata     = value_r;
      count_nxt = count_r + CNT_W'(1);
    end

    if (ctl.wr_move) begin
      wr_en     = 1'b1;
      waddr     = pos_r;
      wdata     = rdata_r;
      count_nxt = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
    end
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pos_r     <= pos_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (ctl.out_load) begin
      out_ok_r     <= ctl.res_ok;
      out_status_r <= ctl.res_status;
      out_sample_r <= ctl.res_sample ? rdata_r : '0;
      out_count_r  <= count_r;
    end
  end

  assign out_ok           = out_ok_r;
  assign out_status       = out_status_r;
  assign out_sample_value = out_sample_r;
  assign out_count        = out_count_r;

endmodule

// File: design/rse_ctrl.sv
module rse_ctrl
  import rse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rse_sts_t sts,
  output rse_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_READ_LAST,
    S_MOVE,
    S_DIV,
    S_READ_SMP,
    S_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_smp_r, res_smp_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    res_ok_nxt     = res_ok_r;
    res_status_nxt = res_status_r;
    res_smp_nxt    = res_smp_r;
    ctl            = '0;
    ctl.res_ok     = res_ok_r;
    ctl.res_status = res_status_r;
    ctl.res_sample = res_smp_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_ok_nxt     = 1'b0;
        res_status_nxt = STATUS_DONE;
        res_smp_nxt    = 1'b0;
        if (sts.cmd == CMD_INSERT || sts.cmd == CMD_REMOVE) begin
          state_nxt = S_SCAN;
        end else if (sts.cmd == CMD_SAMPLE) begin
          if (sts.count_zero) begin
            res_status_nxt = STATUS_EMPTY;
            state_nxt      = S_FINISH;
          end else begin
            state_nxt = S_DIV;
          end
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.hit) begin
          if (sts.cmd == CMD_INSERT) begin
            res_status_nxt = STATUS_EXISTS;
            state_nxt      = S_FINISH;
          end else begin
            state_nxt = S_READ_LAST;
          end
        end else if (sts.miss) begin
          if (sts.cmd == CMD_INSERT) begin
            if (sts.full) begin
              res_status_nxt = STATUS_FULL;
            end else begin
              ctl.wr_append = 1'b1;
              res_ok_nxt    = 1'b1;
            end
          end else begin
            res_status_nxt = STATUS_EXISTS;
          end
          state_nxt = S_FINISH;
        end
      end
      S_READ_LAST: begin
        ctl.rd_last = 1'b1;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        ctl.wr_move = 1'b1;
        res_ok_nxt  = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_READ_SMP;
        end else begin
          ctl.div_step = 1'b1;
        end
      end
      S_READ_SMP: begin
        ctl.rd_sample = 1'b1;
        res_ok_nxt    = 1'b1;
        res_smp_nxt   = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      res_ok_r     <= 1'b0;
      res_status_r <= STATUS_DONE;
      res_smp_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      res_ok_r     <= res_ok_nxt;
      res_status_r <= res_status_nxt;
      res_smp_r    <= res_smp_nxt;
    end
  end

endmodule
